### src/imu_complementary_filter_core_macros.svh
// ----------------------------------------------------------------------------
// IMU complementary filter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_CORE_MACROS_SVH

// Same-cycle implication.
`define IMUCF_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("imucf assertion failed");

// Next-cycle implication.
`define IMUCF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("imucf assertion failed");

`endif

### src/imucf_pkg.sv
// ----------------------------------------------------------------------------
// IMU complementary filter package
// Sequencer states, register indexes and datapath widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imucf_pkg;

    localparam int W_WORD    = 16;
    localparam int W_OUT     = 32;
    localparam int NUM_CFG   = 8;
    localparam int W_CFG_IDX = 3;
    localparam int NUM_HELD  = 6;
    localparam int NUM_AVG   = 6;

    // shared multiplier: 17-bit signed gain/step times 34-bit signed operand
    localparam int W_MUL_A = 17;
    localparam int W_MUL_B = 34;
    localparam int W_PROD  = W_MUL_A + W_MUL_B;
    localparam int W_SUM   = W_PROD + 1;
    localparam int GAIN_SHIFT = 15;

    // register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_GYRO_WEIGHT   = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_ACCEL_WEIGHT  = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_TIME_STEP     = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_ACC_ROLL_OFS  = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_ACC_PITCH_OFS = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_GYR_PITCH_OFS = 3'd5;
    localparam logic [W_CFG_IDX-1:0] CFG_GYR_ROLL_OFS  = 3'd6;
    localparam logic [W_CFG_IDX-1:0] CFG_GYR_YAW_OFS   = 3'd7;

    // held word slots
    localparam int H_ACC_ROLL  = 0;
    localparam int H_ACC_PITCH = 1;
    localparam int H_ACC_VERT  = 2;
    localparam int H_GYR_PITCH = 3;
    localparam int H_GYR_ROLL  = 4;
    localparam int H_GYR_YAW   = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_GAIN,
        S_ACC,
        S_FUSE,
        S_AVG,
        S_DONE
    } t_state;

endpackage

### src/imu_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// IMU complementary filter core
// Calibrates gyro/accel words, fuses pitch and roll, keeps six running
// averages; the fusion products all share one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) moves one sample-period word: a fresh
//   flag and six raw sensor words. Output channel (o_valid / i_stall) moves
//   one result word of eight signed Q24.8 values.
//   From accept to o_valid each word goes through the rate product, gyro
//   gain and accel gain products, then sum and saturate, for pitch then
//   roll, then averaging and the output load. The block takes one word at
//   a time; o_stall is high from accept until the result is loaded into
//   the output register, so a new word is taken only after the last
//   result has been loaded.
//   The output register holds a result while i_stall is high; the next word
//   may be accepted and worked on meanwhile, and its result waits in the
//   sequencer until the register is free.
//   Reset (i_rst_n low, synchronous) clears registers, held words, angles
//   and averages to zero and drops any pending result.
//   Configuration writes (i_cfg_we) must come only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "imu_complementary_filter_core_macros.svh"

module imu_complementary_filter_core
    import imucf_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [W_CFG_IDX-1:0]        i_cfg_index,
    input  logic [W_WORD-1:0]           i_cfg_data,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_fresh_sample,
    input  logic signed [W_WORD-1:0]    i_accel_x,
    input  logic signed [W_WORD-1:0]    i_accel_y,
    input  logic signed [W_WORD-1:0]    i_accel_z,
    input  logic signed [W_WORD-1:0]    i_gyro_x,
    input  logic signed [W_WORD-1:0]    i_gyro_y,
    input  logic signed [W_WORD-1:0]    i_gyro_z,

    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [W_OUT-1:0]     o_fused_pitch,
    output logic signed [W_OUT-1:0]     o_fused_roll,
    output logic signed [W_OUT-1:0]     o_avg_accel_pitch,
    output logic signed [W_OUT-1:0]     o_avg_accel_roll,
    output logic signed [W_OUT-1:0]     o_avg_accel_vertical,
    output logic signed [W_OUT-1:0]     o_avg_gyro_pitch,
    output logic signed [W_OUT-1:0]     o_avg_gyro_roll,
    output logic signed [W_OUT-1:0]     o_avg_gyro_yaw
);

    localparam int RATE_SHIFT = W_WORD - FRACTION_BITS;

    t_state                    r_state, n_state;
    logic                      r_axis;
    logic [W_WORD-1:0]         r_cfg   [NUM_CFG];
    logic [W_WORD-1:0]         r_held  [NUM_HELD];
    logic signed [W_OUT-1:0]   r_fused [2];
    logic signed [W_OUT-1:0]   r_avg   [NUM_AVG];
    logic signed [W_PROD-1:0]  r_prod;
    logic signed [W_PROD-1:0]  r_acc;
    logic                      r_out_valid;

    logic                      w_in_accept;
    logic                      w_out_free;
    logic signed [W_MUL_A-1:0] w_mul_a;
    logic signed [W_MUL_B-1:0] w_mul_b;
    logic signed [W_PROD-1:0]  w_prod;
    logic signed [W_PROD-1:0]  w_rate_term;
    logic signed [W_MUL_B-1:0] w_inner;
    logic [W_WORD-1:0]         w_rate_word;
    logic [W_WORD-1:0]         w_acc_word;
    logic signed [W_OUT-1:0]   w_angle;
    logic signed [W_SUM-1:0]   w_sum;
    logic signed [W_SUM-1:0]   w_shifted;
    logic signed [W_OUT-1:0]   w_fused_sat;
    logic signed [W_OUT-1:0]   w_avg_x [NUM_AVG];
    logic signed [W_OUT-1:0]   w_avg_new [NUM_AVG];

    assign w_in_accept = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;

    // operands of the axis under work
    assign w_rate_word = r_axis ? r_held[H_GYR_ROLL] : r_held[H_GYR_PITCH];
    assign w_acc_word  = r_axis ? r_held[H_ACC_ROLL] : r_held[H_ACC_PITCH];
    assign w_angle     = r_axis ? r_fused[1] : r_fused[0];

    assign w_rate_term = r_prod >>> RATE_SHIFT;
    assign w_inner     = $signed({{(W_MUL_B-W_OUT){w_angle[W_OUT-1]}}, w_angle})
                       + w_rate_term[W_MUL_B-1:0];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_RATE: begin
                w_mul_a = $signed({1'b0, r_cfg[CFG_TIME_STEP]});
                w_mul_b = $signed({{(W_MUL_B-W_WORD){w_rate_word[W_WORD-1]}}, w_rate_word});
            end
            S_GAIN: begin
                w_mul_a = $signed({1'b0, r_cfg[CFG_GYRO_WEIGHT]});
                w_mul_b = w_inner;
            end
            S_ACC: begin
                w_mul_a = $signed({1'b0, r_cfg[CFG_ACCEL_WEIGHT]});
                w_mul_b = $signed({{(W_MUL_B-W_WORD){w_acc_word[W_WORD-1]}}, w_acc_word});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // gyro path plus scaled accel path, floor by 2^15, clamp to 32 bits
    assign w_sum     = $signed({r_acc[W_PROD-1], r_acc})
                     + ($signed({r_prod[W_PROD-1], r_prod}) <<< FRACTION_BITS);
    assign w_shifted = w_sum >>> GAIN_SHIFT;

    always_comb begin
        if (&w_shifted[W_SUM-1:W_OUT-1] || ~|w_shifted[W_SUM-1:W_OUT-1]) begin
            w_fused_sat = w_shifted[W_OUT-1:0];
        end else if (w_shifted[W_SUM-1]) begin
            w_fused_sat = {1'b1, {(W_OUT-1){1'b0}}};
        end else begin
            w_fused_sat = {1'b0, {(W_OUT-1){1'b1}}};
        end
    end

    // running average inputs
    always_comb begin
        w_avg_x[0] = r_fused[0];
        w_avg_x[1] = r_fused[1];
        for (int k = 2; k < NUM_AVG; k++) begin
            w_avg_x[k] = $signed({{(W_OUT-W_WORD){r_held[k][W_WORD-1]}}, r_held[k]})
                       <<< FRACTION_BITS;
        end
        for (int k = 0; k < NUM_AVG; k++) begin
            w_avg_new[k] = W_OUT'(($signed({r_avg[k][W_OUT-1], r_avg[k]})
                         + $signed({w_avg_x[k][W_OUT-1], w_avg_x[k]})) >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: n_state = S_GAIN;
            S_GAIN: n_state = S_ACC;
            S_ACC:  n_state = S_FUSE;
            S_FUSE: n_state = r_axis ? S_AVG : S_RATE;
            S_AVG:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_CFG; k++) begin
                r_cfg[k] <= '0;
            end
            for (int k = 0; k < NUM_HELD; k++) begin
                r_held[k] <= '0;
            end
            for (int k = 0; k < NUM_AVG; k++) begin
                r_avg[k] <= '0;
            end
            r_fused[0] <= '0;
            r_fused[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end

            if (w_in_accept) begin
                r_axis <= 1'b0;
                // latch calibrated words, wrap at 16 bits; vertical accel raw
                if (i_fresh_sample) begin
                    r_held[H_ACC_ROLL]  <= i_accel_x - r_cfg[CFG_ACC_ROLL_OFS];
                    r_held[H_ACC_PITCH] <= i_accel_y - r_cfg[CFG_ACC_PITCH_OFS];
                    r_held[H_ACC_VERT]  <= i_accel_z;
                    r_held[H_GYR_PITCH] <= i_gyro_x - r_cfg[CFG_GYR_PITCH_OFS];
                    r_held[H_GYR_ROLL]  <= i_gyro_y - r_cfg[CFG_GYR_ROLL_OFS];
                    r_held[H_GYR_YAW]   <= i_gyro_z - r_cfg[CFG_GYR_YAW_OFS];
                end
            end

            if (r_state == S_FUSE) begin
                r_fused[r_axis] <= w_fused_sat;
                r_axis          <= 1'b1;
            end

            if (r_state == S_AVG) begin
                for (int k = 0; k < NUM_AVG; k++) begin
                    r_avg[k] <= w_avg_new[k];
                end
            end

            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // multiplier pipeline and output payload
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_state == S_ACC) begin
            r_acc <= r_prod;
        end
        if (r_state == S_DONE && w_out_free) begin
            o_fused_pitch        <= r_fused[0];
            o_fused_roll         <= r_fused[1];
            o_avg_accel_pitch    <= r_avg[0];
            o_avg_accel_roll     <= r_avg[1];
            o_avg_accel_vertical <= r_avg[2];
            o_avg_gyro_pitch     <= r_avg[3];
            o_avg_gyro_roll      <= r_avg[4];
            o_avg_gyro_yaw       <= r_avg[5];
        end
    end

    `IMUCF_ASSERT_NEXT(a_accept_starts_pitch, w_in_accept, r_state == S_RATE && !r_axis)
    `IMUCF_ASSERT_NEXT(a_roll_fuse_to_avg, r_state == S_FUSE && r_axis, r_state == S_AVG)
    `IMUCF_ASSERT_NEXT(a_done_waits, r_state == S_DONE && !w_out_free, r_state == S_DONE)
    `IMUCF_ASSERT_NEXT(a_done_loads, r_state == S_DONE && w_out_free,
                       o_valid && r_state == S_IDLE)

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU complementary filter core testbench
// Drives sample words through the valid/stall input channel under random
// idling and a long output hold-off. A bit-true model of the calibration,
// fusion and averaging math predicts every result word, and a scoreboard
// checks each field as words leave the output channel.
// ----------------------------------------------------------------------------

module testbench;
    import imucf_pkg::*;

    localparam int FRAC        = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 23;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 24;
    localparam int HOLD_OFF    = 250;
    localparam int NUM_FIELDS  = 8;

    localparam logic [W_WORD-1:0] MAXW = 16'h7FFF;
    localparam logic [W_WORD-1:0] MINW = 16'h8000;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef struct {
        logic                     fresh;
        logic signed [W_WORD-1:0] accel_x;
        logic signed [W_WORD-1:0] accel_y;
        logic signed [W_WORD-1:0] accel_z;
        logic signed [W_WORD-1:0] gyro_x;
        logic signed [W_WORD-1:0] gyro_y;
        logic signed [W_WORD-1:0] gyro_z;
    } t_sample;

    typedef struct packed {
        logic signed [W_OUT-1:0] fused_pitch;
        logic signed [W_OUT-1:0] fused_roll;
        logic signed [W_OUT-1:0] avg_accel_pitch;
        logic signed [W_OUT-1:0] avg_accel_roll;
        logic signed [W_OUT-1:0] avg_accel_vertical;
        logic signed [W_OUT-1:0] avg_gyro_pitch;
        logic signed [W_OUT-1:0] avg_gyro_roll;
        logic signed [W_OUT-1:0] avg_gyro_yaw;
    } t_fusion;

    typedef logic [NUM_CFG-1:0][W_WORD-1:0] t_reg_set;

    string field_name [NUM_FIELDS] = '{
        "fused_pitch", "fused_roll", "avg_accel_pitch", "avg_accel_roll",
        "avg_accel_vertical", "avg_gyro_pitch", "avg_gyro_roll", "avg_gyro_yaw"
    };

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_we       = 1'b0;
    logic [W_CFG_IDX-1:0]     i_cfg_index    = '0;
    logic [W_WORD-1:0]        i_cfg_data     = '0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic                     i_fresh_sample = 1'b0;
    logic signed [W_WORD-1:0] i_accel_x      = '0;
    logic signed [W_WORD-1:0] i_accel_y      = '0;
    logic signed [W_WORD-1:0] i_accel_z      = '0;
    logic signed [W_WORD-1:0] i_gyro_x       = '0;
    logic signed [W_WORD-1:0] i_gyro_y       = '0;
    logic signed [W_WORD-1:0] i_gyro_z       = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic signed [W_OUT-1:0]  o_fused_pitch;
    logic signed [W_OUT-1:0]  o_fused_roll;
    logic signed [W_OUT-1:0]  o_avg_accel_pitch;
    logic signed [W_OUT-1:0]  o_avg_accel_roll;
    logic signed [W_OUT-1:0]  o_avg_accel_vertical;
    logic signed [W_OUT-1:0]  o_avg_gyro_pitch;
    logic signed [W_OUT-1:0]  o_avg_gyro_roll;
    logic signed [W_OUT-1:0]  o_avg_gyro_yaw;

    // filter mirror
    logic [W_WORD-1:0] reg_val     [NUM_CFG];
    logic [W_WORD-1:0] held_word   [NUM_HELD];
    int                fused_angle [2];
    int                avg_val     [NUM_AVG];
    t_fusion           expected_fusion [$];

    bit idle_on     = 1'b1;
    int hold_cycles = 0;
    int cycle_count = 0;
    int fault_count = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int settings_loaded = 0;

    imu_complementary_filter_core #(
        .FRACTION_BITS        (FRAC)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_fresh_sample       (i_fresh_sample),
        .i_accel_x            (i_accel_x),
        .i_accel_y            (i_accel_y),
        .i_accel_z            (i_accel_z),
        .i_gyro_x             (i_gyro_x),
        .i_gyro_y             (i_gyro_y),
        .i_gyro_z             (i_gyro_z),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_fused_pitch        (o_fused_pitch),
        .o_fused_roll         (o_fused_roll),
        .o_avg_accel_pitch    (o_avg_accel_pitch),
        .o_avg_accel_roll     (o_avg_accel_roll),
        .o_avg_accel_vertical (o_avg_accel_vertical),
        .o_avg_gyro_pitch     (o_avg_gyro_pitch),
        .o_avg_gyro_roll      (o_avg_gyro_roll),
        .o_avg_gyro_yaw       (o_avg_gyro_yaw)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_fusion.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit take_break();
        return idle_on && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // one axis of the complementary filter, floor shifts, saturate at the end
    function automatic int fuse_axis(input int angle, input logic [W_WORD-1:0] rate_word,
                                     input logic [W_WORD-1:0] tilt_word);
        longint rate;
        longint tilt;
        longint step;
        longint gyro_gain;
        longint accel_gain;
        longint inner;
        longint total;
        rate       = longint'($signed(rate_word));
        tilt       = longint'($signed(tilt_word));
        step       = longint'(reg_val[CFG_TIME_STEP]);
        gyro_gain  = longint'(reg_val[CFG_GYRO_WEIGHT]);
        accel_gain = longint'(reg_val[CFG_ACCEL_WEIGHT]);
        inner = longint'(angle) + ((rate * step) >>> (16 - FRAC));
        total = (gyro_gain * inner + accel_gain * (tilt <<< FRAC)) >>> GAIN_SHIFT;
        if (total > SAT_HI)
            return int'(SAT_HI);
        if (total < SAT_LO)
            return int'(SAT_LO);
        return int'(total);
    endfunction

    function automatic int halve_sum(input int avg, input longint x);
        return int'((longint'(avg) + x) >>> 1);
    endfunction

    function automatic t_fusion filter_step(input t_sample s);
        t_fusion r;
        if (s.fresh) begin
            held_word[H_ACC_ROLL]  = s.accel_x - reg_val[CFG_ACC_ROLL_OFS];
            held_word[H_ACC_PITCH] = s.accel_y - reg_val[CFG_ACC_PITCH_OFS];
            held_word[H_ACC_VERT]  = s.accel_z;
            held_word[H_GYR_PITCH] = s.gyro_x - reg_val[CFG_GYR_PITCH_OFS];
            held_word[H_GYR_ROLL]  = s.gyro_y - reg_val[CFG_GYR_ROLL_OFS];
            held_word[H_GYR_YAW]   = s.gyro_z - reg_val[CFG_GYR_YAW_OFS];
        end
        fused_angle[0] = fuse_axis(fused_angle[0], held_word[H_GYR_PITCH],
                                   held_word[H_ACC_PITCH]);
        fused_angle[1] = fuse_axis(fused_angle[1], held_word[H_GYR_ROLL],
                                   held_word[H_ACC_ROLL]);
        avg_val[0] = halve_sum(avg_val[0], fused_angle[0]);
        avg_val[1] = halve_sum(avg_val[1], fused_angle[1]);
        // average slots 2..5 line up with held slots vertical..yaw
        for (int k = H_ACC_VERT; k < NUM_HELD; k++)
            avg_val[k] = halve_sum(avg_val[k], longint'($signed(held_word[k])) <<< FRAC);
        r = '{fused_angle[0], fused_angle[1], avg_val[0], avg_val[1],
              avg_val[2], avg_val[3], avg_val[4], avg_val[5]};
        return r;
    endfunction

    function automatic t_sample random_sample(input int fresh_pct);
        t_sample           s;
        logic [W_WORD-1:0] w [6];
        for (int k = 0; k < 6; k++) begin
            case ($urandom_range(3))
                0: w[k] = $urandom_range(1) ? MAXW : MINW;
                1: w[k] = W_WORD'($urandom_range(512) - 256);
                default: w[k] = W_WORD'($urandom);
            endcase
        end
        s = '{($urandom_range(99) < fresh_pct), w[0], w[1], w[2], w[3], w[4], w[5]};
        return s;
    endfunction

    // keep valid up across back-to-back words; the block latches at the edge
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_fresh_sample <= s.fresh;
        i_accel_x      <= s.accel_x;
        i_accel_y      <= s.accel_y;
        i_accel_z      <= s.accel_z;
        i_gyro_x       <= s.gyro_x;
        i_gyro_y       <= s.gyro_y;
        i_gyro_z       <= s.gyro_z;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_fusion.push_back(filter_step(s));
        samples_sent++;
    endtask

    task automatic await_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_fusion.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_settings(input t_reg_set v);
        for (int k = 0; k < NUM_CFG; k++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= W_CFG_IDX'(k);
            i_cfg_data  <= v[k];
            @(posedge i_clk);
            reg_val[k] = v[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_stall <= take_break();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_fusion          got;
        t_fusion          want;
        logic [W_OUT-1:0] w;
        logic [W_OUT-1:0] g;
        int               lsb;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_fused_pitch, o_fused_roll, o_avg_accel_pitch, o_avg_accel_roll,
                    o_avg_accel_vertical, o_avg_gyro_pitch, o_avg_gyro_roll,
                    o_avg_gyro_yaw};
            if (expected_fusion.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("cycle %0d: result word with nothing outstanding", cycle_count);
            end else begin
                want = expected_fusion.pop_front();
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    lsb = (NUM_FIELDS - 1 - k) * W_OUT;
                    w   = want[lsb +: W_OUT];
                    g   = got[lsb +: W_OUT];
                    if (g !== w) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display("cycle %0d: %s expected %0d (%08h) got %0d (%08h)",
                                     cycle_count, field_name[k], $signed(w), w,
                                     $signed(g), g);
                    end
                end
                results_checked++;
            end
        end
    end

    // reset values: gains zero, so both angles stay at zero
    task automatic test_power_on();
        send_sample(t_sample'{1'b1, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW});
        send_sample(t_sample'{1'b1, MINW, MINW, MINW, MINW, MINW, MINW});
        // stale flag: payload must be ignored
        send_sample(t_sample'{1'b0, 16'h1234, 16'h5678, 16'h0F0F, 16'hAAAA, 16'h5555, 16'hFFFF});
        await_results();
    endtask

    // offsets at both ends force calibration wraparound
    task automatic test_field_extremes();
        t_reg_set cfg;
        cfg = '0;
        cfg[CFG_GYRO_WEIGHT]   = 16'd30000;
        cfg[CFG_ACCEL_WEIGHT]  = 16'd2768;
        cfg[CFG_TIME_STEP]     = 16'hFFFF;
        cfg[CFG_ACC_ROLL_OFS]  = MAXW;
        cfg[CFG_ACC_PITCH_OFS] = MINW;
        cfg[CFG_GYR_PITCH_OFS] = MINW;
        cfg[CFG_GYR_ROLL_OFS]  = MAXW;
        cfg[CFG_GYR_YAW_OFS]   = 16'hFFFF;
        load_settings(cfg);
        send_sample(t_sample'{1'b1, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW});
        send_sample(t_sample'{1'b1, MINW, MINW, MINW, MINW, MINW, MINW});
        send_sample(t_sample'{1'b1, MAXW, MINW, 16'h0000, 16'hFFFF, 16'h0001, MINW});
        send_sample(t_sample'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        await_results();
    endtask

    // gains above one drive both angles into the rails
    task automatic test_saturation();
        t_reg_set cfg;
        cfg = '0;
        cfg[CFG_GYRO_WEIGHT]  = 16'hFFFF;
        cfg[CFG_ACCEL_WEIGHT] = 16'hFFFF;
        cfg[CFG_TIME_STEP]    = 16'hFFFF;
        load_settings(cfg);
        repeat (8)
            send_sample(t_sample'{1'b1, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW});
        await_results();
        // drop the gyro path to pull the angles negative
        cfg[CFG_GYRO_WEIGHT] = 16'h0000;
        load_settings(cfg);
        send_sample(t_sample'{1'b1, MINW, MINW, MINW, MINW, MINW, MINW});
        await_results();
        cfg[CFG_GYRO_WEIGHT] = 16'hFFFF;
        load_settings(cfg);
        for (int n = 0; n < 8; n++)
            send_sample(t_sample'{n[0], MINW, MINW, MINW, MINW, MINW, MINW});
        await_results();
    endtask

    // hold the output long enough that the block backs up into its input
    task automatic test_back_pressure();
        hold_cycles = HOLD_OFF;
        repeat (14)
            send_sample(random_sample(70));
        await_results();
    endtask

    task automatic test_random_phases();
        t_reg_set cfg;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    cfg = '{default: MINW};
                    cfg[CFG_GYRO_WEIGHT]  = 16'h0000;
                    cfg[CFG_ACCEL_WEIGHT] = 16'h8000;
                    cfg[CFG_TIME_STEP]    = 16'h0000;
                end
                1: begin
                    cfg = '{default: MAXW};
                    cfg[CFG_GYRO_WEIGHT]  = 16'hFFFF;
                    cfg[CFG_ACCEL_WEIGHT] = 16'h0000;
                    cfg[CFG_TIME_STEP]    = 16'hFFFF;
                end
                default: begin
                    if ($urandom_range(3) == 0) begin
                        cfg[CFG_GYRO_WEIGHT]  = W_WORD'($urandom);
                        cfg[CFG_ACCEL_WEIGHT] = W_WORD'($urandom);
                    end else begin
                        cfg[CFG_GYRO_WEIGHT]  = W_WORD'($urandom_range(32768));
                        cfg[CFG_ACCEL_WEIGHT] = 16'h8000 - cfg[CFG_GYRO_WEIGHT];
                    end
                    cfg[CFG_TIME_STEP] = W_WORD'($urandom);
                    for (int k = CFG_ACC_ROLL_OFS; k <= CFG_GYR_YAW_OFS; k++)
                        cfg[k] = $urandom_range(1) ? W_WORD'($urandom)
                                                   : W_WORD'($urandom_range(1024) - 512);
                end
            endcase
            load_settings(cfg);
            // one phase runs with neither side idling
            idle_on = (phase != 2);
            for (int n = 0; n < 110; n++) begin
                if (n == 55)
                    await_results();
                send_sample(random_sample(phase == 3 ? 20 : 75));
            end
            await_results();
            idle_on = 1'b1;
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_CFG; k++)
            reg_val[k] = '0;
        for (int k = 0; k < NUM_HELD; k++)
            held_word[k] = '0;
        for (int k = 0; k < NUM_AVG; k++)
            avg_val[k] = 0;
        fused_angle[0] = 0;
        fused_angle[1] = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on();
        test_field_extremes();
        test_saturation();
        test_back_pressure();
        test_random_phases();

        await_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fault_count += expected_fusion.size();

        $display("checked %0d result words from %0d samples over %0d register settings",
                 results_checked, samples_sent, settings_loaded);
        $display("covered stale samples, offset wrap, rail saturation, %0d-cycle output hold",
                 HOLD_OFF);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/imucf_pkg.sv
src/imu_complementary_filter_core.sv
dv/testbench.sv
